### hdl/assert_macros.svh
// Assertion macros used by the calendar adjust design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/cabft_pkg.sv
// Constants and BCD helper functions for the calendar adjust block.
package cabft_pkg;

    localparam logic [31:0] FIXED_FAT_TIME = 32'd1449957149;

    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] MINUTE_MAX  = 8'd59;
    localparam logic [7:0] MONTH_MIN   = 8'd1;
    localparam logic [7:0] MONTH_MAX   = 8'd12;
    localparam logic [7:0] DAY_MIN     = 8'd1;
    localparam logic [7:0] YEAR_MIN    = 8'd22;
    localparam logic [7:0] YEAR_MAX    = 8'd40;
    localparam logic [7:0] FAT_YEAR_BIAS = 8'd20;
    localparam logic [7:0] WEEKDAY_BYTE  = 8'd6;

    localparam logic KIND_ADJUST   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    localparam logic [2:0] SEL_HOUR   = 3'd0;
    localparam logic [2:0] SEL_MINUTE = 3'd1;
    localparam logic [2:0] SEL_DAY    = 3'd2;
    localparam logic [2:0] SEL_MONTH  = 3'd3;
    localparam logic [2:0] SEL_YEAR   = 3'd4;

    localparam logic [1:0] START_TIME = 2'd0;
    localparam logic [1:0] START_DATE = 2'd3;
    localparam logic [2:0] COUNT_TIME = 3'd3;
    localparam logic [2:0] COUNT_DATE = 3'd4;

    localparam logic [3:0] TENS_MASK_MIN_SEC = 4'd7;
    localparam logic [3:0] TENS_MASK_HR_DATE = 4'd3;
    localparam logic [3:0] TENS_MASK_MONTH   = 4'd1;
    localparam logic [3:0] TENS_MASK_YEAR    = 4'd15;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 72;

    // Step with wraparound between lo and hi.
    function automatic logic [7:0] step_wrap(input logic [7:0] v, input logic [7:0] lo,
                                             input logic [7:0] hi, input logic down);
        logic [7:0] r;
        if (down) begin
            r = (v > lo) ? v - 8'd1 : hi;
        end else begin
            r = (v < hi) ? v + 8'd1 : lo;
        end
        return r;
    endfunction

    function automatic logic [7:0] day_limit(input logic [4:0] m);
        logic [7:0] r;
        if (m == 5'd2) begin
            r = 8'd29;
        end else if (m == 5'd4 || m == 5'd6 || m == 5'd9 || m == 5'd11) begin
            r = 8'd30;
        end else begin
            r = 8'd31;
        end
        return r;
    endfunction

    // Divide by ten through a reciprocal multiply; exact for any 8-bit value.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  q10;
        logic [7:0]  rem;
        prod = {8'd0, v} * 16'd205;
        q    = prod[15:11];
        q10  = 8'({q, 3'b000}) + 8'({q, 1'b0});
        rem  = v - q10;
        return {q[3:0], rem[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] r, input logic [3:0] mask);
        logic [3:0] t;
        t = r[7:4] & mask;
        return 8'({t, 3'b000}) + 8'({t, 1'b0}) + {4'd0, r[3:0]};
    endfunction

endpackage

### hdl/calendar_adjust_bcd_fat_time.sv
// Calendar adjust and FAT timestamp block for a BCD real-time clock.
// Pipeline: input register, then result register.
// Throughput: one item per cycle while m_tready is high; the counters update in the result cycle, so the
// next item sees them at once.
// Reset (aresetn low, synchronous): time 00:00, day 1, month 1, year 22, RTC enabled,
// both pipeline stages empty.
`include "assert_macros.svh"

module calendar_adjust_bcd_fat_time (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // rtc_enabled
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // field_select[2:0], direction[3], seconds_reg[11:4], minutes_reg[19:12],
    // hours_reg[27:20], date_reg[35:28], month_reg[43:36], year_reg[51:44], zero[55:52]
    input  logic [cabft_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic        s_tuser,       // kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_start[1:0], write_count[4:2], write_byte0[12:5], write_byte1[20:13],
    // write_byte2[28:21], write_byte3[36:29], fat_time[68:37], zero[71:69]
    output logic [cabft_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]  m_tuser        // write_valid[0], fat_valid[1]
);

    // control
    logic rtc_en_reg;
    logic stg_valid_reg;
    logic out_valid_reg;
    logic advance;

    // input stage payload
    logic       stg_kind_reg;
    logic [2:0] stg_sel_reg;
    logic       stg_dir_reg;
    logic [7:0] stg_sec_reg, stg_min_reg, stg_hour_reg;
    logic [7:0] stg_date_reg, stg_month_reg, stg_year_reg;

    // calendar state
    logic [4:0] hour_reg,  hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [5:0] day_reg,   day_next;
    logic [4:0] month_reg, month_next;
    logic [7:0] year_reg,  year_next;

    // result register
    logic        wr_valid_reg, wr_valid_next;
    logic [1:0]  wr_start_reg, wr_start_next;
    logic [2:0]  wr_count_reg, wr_count_next;
    logic [7:0]  wr_b0_reg, wr_b0_next;
    logic [7:0]  wr_b1_reg, wr_b1_next;
    logic [7:0]  wr_b2_reg, wr_b2_next;
    logic [7:0]  wr_b3_reg, wr_b3_next;
    logic        fat_valid_reg, fat_valid_next;
    logic [31:0] fat_time_reg, fat_time_next;

    // decoded snapshot values
    logic [7:0] dec_sec, dec_min, dec_hour, dec_date, dec_month, dec_year;
    logic [7:0] fat_year;

    assign cfg_ready = 1'b1;
    assign advance   = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !stg_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtc_en_reg    <= 1'b1;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hour_reg      <= 5'd0;
            minute_reg    <= 7'd0;
            day_reg       <= 6'd1;
            month_reg     <= 5'd1;
            year_reg      <= cabft_pkg::YEAR_MIN;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rtc_en_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                stg_valid_reg <= 1'b1;
            end else if (advance) begin
                stg_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                day_reg       <= day_next;
                month_reg     <= month_next;
                year_reg      <= year_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stg_kind_reg  <= s_tuser;
            stg_sel_reg   <= s_tdata[2:0];
            stg_dir_reg   <= s_tdata[3];
            stg_sec_reg   <= s_tdata[11:4];
            stg_min_reg   <= s_tdata[19:12];
            stg_hour_reg  <= s_tdata[27:20];
            stg_date_reg  <= s_tdata[35:28];
            stg_month_reg <= s_tdata[43:36];
            stg_year_reg  <= s_tdata[51:44];
        end
        if (advance) begin
            wr_valid_reg  <= wr_valid_next;
            wr_start_reg  <= wr_start_next;
            wr_count_reg  <= wr_count_next;
            wr_b0_reg     <= wr_b0_next;
            wr_b1_reg     <= wr_b1_next;
            wr_b2_reg     <= wr_b2_next;
            wr_b3_reg     <= wr_b3_next;
            fat_valid_reg <= fat_valid_next;
            fat_time_reg  <= fat_time_next;
        end
    end

    assign dec_sec   = cabft_pkg::from_bcd(stg_sec_reg,   cabft_pkg::TENS_MASK_MIN_SEC);
    assign dec_min   = cabft_pkg::from_bcd(stg_min_reg,   cabft_pkg::TENS_MASK_MIN_SEC);
    assign dec_hour  = cabft_pkg::from_bcd(stg_hour_reg,  cabft_pkg::TENS_MASK_HR_DATE);
    assign dec_date  = cabft_pkg::from_bcd(stg_date_reg,  cabft_pkg::TENS_MASK_HR_DATE);
    assign dec_month = cabft_pkg::from_bcd(stg_month_reg, cabft_pkg::TENS_MASK_MONTH);
    assign dec_year  = cabft_pkg::from_bcd(stg_year_reg,  cabft_pkg::TENS_MASK_YEAR);
    assign fat_year  = dec_year + cabft_pkg::FAT_YEAR_BIAS;

    always_comb begin
        logic sel_ok;
        logic is_time;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        wr_valid_next  = 1'b0;
        wr_start_next  = 2'd0;
        wr_count_next  = 3'd0;
        wr_b0_next     = 8'd0;
        wr_b1_next     = 8'd0;
        wr_b2_next     = 8'd0;
        wr_b3_next     = 8'd0;
        fat_valid_next = 1'b0;
        fat_time_next  = 32'd0;
        sel_ok         = 1'b1;
        is_time        = 1'b1;

        if (stg_kind_reg == cabft_pkg::KIND_ADJUST) begin
            unique case (stg_sel_reg)
                cabft_pkg::SEL_HOUR: begin
                    hour_next = 5'(cabft_pkg::step_wrap({3'd0, hour_reg}, 8'd0,
                                   cabft_pkg::HOUR_MAX, stg_dir_reg));
                end
                cabft_pkg::SEL_MINUTE: begin
                    minute_next = 7'(cabft_pkg::step_wrap({1'b0, minute_reg}, 8'd0,
                                     cabft_pkg::MINUTE_MAX, stg_dir_reg));
                end
                cabft_pkg::SEL_DAY: begin
                    day_next = 6'(cabft_pkg::step_wrap({2'd0, day_reg}, cabft_pkg::DAY_MIN,
                                  cabft_pkg::day_limit(month_reg), stg_dir_reg));
                    is_time  = 1'b0;
                end
                cabft_pkg::SEL_MONTH: begin
                    month_next = 5'(cabft_pkg::step_wrap({3'd0, month_reg}, cabft_pkg::MONTH_MIN,
                                    cabft_pkg::MONTH_MAX, stg_dir_reg));
                    is_time    = 1'b0;
                end
                cabft_pkg::SEL_YEAR: begin
                    year_next = cabft_pkg::step_wrap(year_reg, cabft_pkg::YEAR_MIN,
                                                     cabft_pkg::YEAR_MAX, stg_dir_reg);
                    is_time   = 1'b0;
                end
                default: begin
                    // unknown field: no change, no write
                    sel_ok = 1'b0;
                end
            endcase
            if (sel_ok && rtc_en_reg) begin
                wr_valid_next = 1'b1;
                if (is_time) begin
                    wr_start_next = cabft_pkg::START_TIME;
                    wr_count_next = cabft_pkg::COUNT_TIME;
                    wr_b1_next    = cabft_pkg::to_bcd({1'b0, minute_next});
                    wr_b2_next    = cabft_pkg::to_bcd({3'd0, hour_next});
                end else begin
                    wr_start_next = cabft_pkg::START_DATE;
                    wr_count_next = cabft_pkg::COUNT_DATE;
                    wr_b0_next    = cabft_pkg::WEEKDAY_BYTE;
                    wr_b1_next    = cabft_pkg::to_bcd({2'd0, day_next});
                    wr_b2_next    = cabft_pkg::to_bcd({3'd0, month_next});
                    wr_b3_next    = cabft_pkg::to_bcd(year_next);
                end
            end
        end else begin
            fat_valid_next = 1'b1;
            if (!rtc_en_reg) begin
                fat_time_next = cabft_pkg::FIXED_FAT_TIME;
            end else begin
                minute_next   = dec_min[6:0];
                hour_next     = dec_hour[4:0];
                day_next      = dec_date[5:0];
                month_next    = dec_month[4:0];
                year_next     = dec_year;
                // overlapping fields OR together, upper year bits drop off
                fat_time_next = ({24'd0, fat_year} << 25) | ({24'd0, dec_month} << 21) |
                                ({24'd0, dec_date} << 16) | ({24'd0, dec_hour} << 11) |
                                ({24'd0, dec_min} << 5)   | {25'd0, dec_sec[7:1]};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {fat_valid_reg, wr_valid_reg};
    assign m_tdata  = {3'd0, fat_time_reg, wr_b3_reg, wr_b2_reg, wr_b1_reg, wr_b0_reg,
                       wr_count_reg, wr_start_reg};

    `ASSERT_IMPLIES(a_one_result_kind, aclk, aresetn, out_valid_reg,
        !(wr_valid_reg && fat_valid_reg))
    `ASSERT_IMPLIES(a_write_shape, aclk, aresetn, out_valid_reg && wr_valid_reg,
        (wr_start_reg == cabft_pkg::START_TIME && wr_count_reg == cabft_pkg::COUNT_TIME) ||
        (wr_start_reg == cabft_pkg::START_DATE && wr_count_reg == cabft_pkg::COUNT_DATE))
    `ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg)
    `ASSERT_IMPLIES(a_stall_only_when_full, aclk, aresetn, !s_tready,
        stg_valid_reg && out_valid_reg && !m_tready)

endmodule
